### hdl/cvw_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cvw_pkg
// Shared types and constants for the streaming 3x3 window convolution block.
// ---------------------------------------------------------------------------
package cvw_pkg;

  // Default build-time sizes.
  localparam int DEF_MAX_WIDTH  = 64;
  localparam int DEF_KERNEL_MAX = 3;
  localparam int DEF_PIXEL_BITS = 16;

  // Fixed field widths of the interface.
  localparam int COEFF_BITS  = 16;
  localparam int COEFF_ROWS  = 3;
  localparam int CROW_BITS   = 48;
  localparam int SUM_BITS    = 35;
  localparam int ROW_BITS    = 12;
  localparam int COL_BITS    = 6;
  localparam int WREG_BITS   = 7;
  localparam int HREG_BITS   = 13;
  localparam int KREG_BITS   = 2;
  localparam int CIDX_BITS   = 3;
  localparam int HEIGHT_MAX  = 4096;
  localparam int FIFO_DEPTH  = 4;

  // Configuration register indexes.
  typedef enum logic [CIDX_BITS-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_KERNEL_ROWS  = 3'd2,
    REG_KERNEL_COLS  = 3'd3,
    REG_COEFF_ROW0   = 3'd4,
    REG_COEFF_ROW1   = 3'd5,
    REG_COEFF_ROW2   = 3'd6
  } cvw_reg_t;

  // Geometry settings handed to the front end.
  typedef struct packed {
    logic [WREG_BITS-1:0] image_width;
    logic [HREG_BITS-1:0] image_height;
    logic [KREG_BITS-1:0] kernel_rows;
    logic [KREG_BITS-1:0] kernel_cols;
  } cvw_cfg_t;

  // Position information that travels with each window.
  typedef struct packed {
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic                last;
  } cvw_meta_t;

endpackage

### hdl/cvw_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cvw_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module cvw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; a read at the written address
  // returns the old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/cvw_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cvw_front
// Pixel intake: raster counters, line store, window registers and window
// tap selection. Windows that produce a result are pushed into the queue.
// ---------------------------------------------------------------------------
module cvw_front import cvw_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int KERNEL_MAX = DEF_KERNEL_MAX,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  cvw_cfg_t                                    cfg,
  input  logic                                        in_valid,
  output logic                                        in_stall,
  input  logic [PIXEL_BITS-1:0]                       in_pixel,
  input  logic                                        q_full,
  output logic                                        q_push,
  output logic [KERNEL_MAX*KERNEL_MAX*PIXEL_BITS-1:0] q_taps,
  output cvw_meta_t                                   q_meta
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LW = (KERNEL_MAX - 1) * PIXEL_BITS;

  // Effective geometry after clamping.
  logic [CW:0]           w_eff;
  logic [HREG_BITS-1:0]  h_eff;
  logic [KREG_BITS-1:0]  kr_eff;
  logic [KREG_BITS-1:0]  kc_eff;

  // Raster counters.
  logic [CW-1:0]         col_r, col_nxt;
  logic [ROW_BITS-1:0]   row_r, row_nxt;
  logic                  end_row, end_frame, emit;

  // Stage one.
  logic                  s1_v_r;
  logic                  s1_emit_r;
  logic [PIXEL_BITS-1:0] s1_px_r;
  logic [CW-1:0]         s1_c_r;
  cvw_meta_t             s1_meta_r;
  logic                  acc, s1_go, fire;

  // Line store access.
  logic [LW-1:0]         ram_q, ls_old, ls_new;
  logic [MAX_WIDTH-1:0]  lsv_r;
  logic                  rd_vld_r;
  logic                  last_v_r;
  logic [CW-1:0]         last_addr_r;
  logic [LW-1:0]         last_data_r;

  logic [PIXEL_BITS-1:0] cur [KERNEL_MAX];
  logic [PIXEL_BITS-1:0] win_r [KERNEL_MAX][KERNEL_MAX-1];

  // Clamp the configured sizes into their working ranges.
  always_comb begin
    if (cfg.image_width == '0) begin
      w_eff = (CW+1)'(1);
    end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(cfg.image_width);
    end
    if (cfg.image_height == '0) begin
      h_eff = HREG_BITS'(1);
    end else if (32'(cfg.image_height) > 32'(HEIGHT_MAX)) begin
      h_eff = HREG_BITS'(HEIGHT_MAX);
    end else begin
      h_eff = cfg.image_height;
    end
    if (cfg.kernel_rows == '0) begin
      kr_eff = KREG_BITS'(1);
    end else if (32'(cfg.kernel_rows) > 32'(KERNEL_MAX)) begin
      kr_eff = KREG_BITS'(KERNEL_MAX);
    end else begin
      kr_eff = cfg.kernel_rows;
    end
    if (cfg.kernel_cols == '0) begin
      kc_eff = KREG_BITS'(1);
    end else if (32'(cfg.kernel_cols) > 32'(KERNEL_MAX)) begin
      kc_eff = KREG_BITS'(KERNEL_MAX);
    end else begin
      kc_eff = cfg.kernel_cols;
    end
  end

  // Classify the incoming pixel against the raster position.
  always_comb begin
    end_row   = {1'b0, col_r} >= (w_eff - (CW+1)'(1));
    end_frame = end_row && ({1'b0, row_r} >= (h_eff - HREG_BITS'(1)));
    emit      = (row_r >= ROW_BITS'(kr_eff - KREG_BITS'(1))) &&
                ({1'b0, col_r} >= (CW+1)'(kc_eff - KREG_BITS'(1)));
    if (end_row) begin
      col_nxt = '0;
      row_nxt = end_frame ? '0 : row_r + ROW_BITS'(1);
    end else begin
      col_nxt = col_r + CW'(1);
      row_nxt = row_r;
    end
  end

  // Handshake: stage one holds only when it has a window and the queue is full.
  assign s1_go    = !s1_emit_r || !q_full;
  assign in_stall = s1_v_r && !s1_go;
  assign acc      = in_valid && !in_stall;
  assign fire     = s1_v_r && s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      s1_v_r    <= 1'b0;
      s1_emit_r <= 1'b0;
    end else begin
      if (acc) begin
        col_r     <= col_nxt;
        row_r     <= row_nxt;
        s1_v_r    <= 1'b1;
        s1_emit_r <= emit;
      end else if (s1_go) begin
        s1_v_r    <= 1'b0;
        s1_emit_r <= 1'b0;
      end
    end
  end

  // Stage one payload.
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_px_r       <= in_pixel;
      s1_c_r        <= col_r;
      s1_meta_r.row <= row_r - ROW_BITS'(kr_eff - KREG_BITS'(1));
      s1_meta_r.col <= COL_BITS'(col_r - CW'(kc_eff - KREG_BITS'(1)));
      s1_meta_r.last <= end_frame;
    end
  end

  // Line store: one word per column holding the earlier rows.
  cvw_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk   (clk),
    .we    (fire),
    .waddr (s1_c_r),
    .wdata (ls_new),
    .re    (acc),
    .raddr (col_r),
    .rdata (ram_q)
  );

  // Per-column valid bits stand in for the cleared reset contents.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lsv_r    <= '0;
      rd_vld_r <= 1'b0;
      last_v_r <= 1'b0;
    end else begin
      if (acc) begin
        rd_vld_r <= lsv_r[col_r];
      end
      if (fire) begin
        lsv_r[s1_c_r] <= 1'b1;
        last_v_r      <= 1'b1;
      end
    end
  end

  // The latest write is kept so that a read issued on the same edge sees it.
  always_ff @(posedge clk) begin
    if (fire) begin
      last_addr_r <= s1_c_r;
      last_data_r <= ls_new;
    end
  end

  // Current column of the window and the updated line store word.
  always_comb begin
    if (last_v_r && (last_addr_r == s1_c_r)) begin
      ls_old = last_data_r;
    end else if (rd_vld_r) begin
      ls_old = ram_q;
    end else begin
      ls_old = '0;
    end
    cur[0] = s1_px_r;
    for (int a = 1; a < KERNEL_MAX; a++) begin
      cur[a] = ls_old[(a-1)*PIXEL_BITS +: PIXEL_BITS];
    end
    for (int a = 0; a < KERNEL_MAX - 1; a++) begin
      ls_new[a*PIXEL_BITS +: PIXEL_BITS] = cur[a];
    end
  end

  // Window registers shift one column per transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < KERNEL_MAX; a++) begin
        for (int b = 0; b < KERNEL_MAX - 1; b++) begin
          win_r[a][b] <= '0;
        end
      end
    end else if (fire) begin
      for (int a = 0; a < KERNEL_MAX; a++) begin
        win_r[a][0] <= cur[a];
        for (int b = 1; b < KERNEL_MAX - 1; b++) begin
          win_r[a][b] <= win_r[a][b-1];
        end
      end
    end
  end

  // Map stored pixels onto kernel positions; unused positions read as zero.
  always_comb begin
    logic [KREG_BITS-1:0] ra;
    logic [KREG_BITS-1:0] cb;
    q_taps = '0;
    for (int ki = 0; ki < KERNEL_MAX; ki++) begin
      for (int kj = 0; kj < KERNEL_MAX; kj++) begin
        ra = kr_eff - KREG_BITS'(1) - KREG_BITS'(ki);
        cb = kc_eff - KREG_BITS'(1) - KREG_BITS'(kj);
        if ((KREG_BITS'(ki) < kr_eff) && (KREG_BITS'(kj) < kc_eff)) begin
          for (int a = 0; a < KERNEL_MAX; a++) begin
            for (int b = 0; b < KERNEL_MAX; b++) begin
              if ((ra == KREG_BITS'(a)) && (cb == KREG_BITS'(b))) begin
                if (b == 0) begin
                  q_taps[(ki*KERNEL_MAX+kj)*PIXEL_BITS +: PIXEL_BITS] = cur[a];
                end else begin
                  q_taps[(ki*KERNEL_MAX+kj)*PIXEL_BITS +: PIXEL_BITS] =
                    win_r[a][(b > 0) ? b-1 : 0];
                end
              end
            end
          end
        end
      end
    end
  end

  assign q_push = fire && s1_emit_r;
  assign q_meta = s1_meta_r;

endmodule

### hdl/cvw_fifo.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cvw_fifo
// Short queue of finished windows between the front end and the MAC.
// ---------------------------------------------------------------------------
module cvw_fifo import cvw_pkg::*; #(
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] wdata,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output logic [DW-1:0] rdata
);

  localparam int PW = $clog2(FIFO_DEPTH);

  logic [DW-1:0] mem_r [FIFO_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign full  = cnt_r == (PW+1)'(FIFO_DEPTH);
  assign empty = cnt_r == '0;
  assign rdata = mem_r[rp_r];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + PW'(1);
      end
      if (pop) begin
        rp_r <= rp_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (PW+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (PW+1)'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

endmodule

### hdl/cvw_mac.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cvw_mac
// Back end: parallel products, per-row sums and the final sum, registered
// in three stages, the last being the output register to the result channel.
// ---------------------------------------------------------------------------
module cvw_mac import cvw_pkg::*; #(
  parameter int KERNEL_MAX = DEF_KERNEL_MAX,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic [COEFF_ROWS*CROW_BITS-1:0]             coeffs,
  input  logic                                        q_empty,
  output logic                                        q_pop,
  input  logic [KERNEL_MAX*KERNEL_MAX*PIXEL_BITS-1:0] q_taps,
  input  cvw_meta_t                                   q_meta,
  output logic                                        out_valid,
  input  logic                                        out_stall,
  output logic [SUM_BITS-1:0]                         out_conv_sum,
  output cvw_meta_t                                   out_meta
);

  localparam int KK  = KERNEL_MAX * KERNEL_MAX;
  localparam int PW  = PIXEL_BITS + COEFF_BITS;
  localparam int RW  = PW + 2;
  localparam int SW  = PW + 4;

  logic signed [PW-1:0] p_r [KK];
  logic signed [PW-1:0] p_nxt [KK];
  logic signed [RW-1:0] rs_r [KERNEL_MAX];
  logic signed [RW-1:0] rs_nxt [KERNEL_MAX];
  logic signed [SW-1:0] fs;
  cvw_meta_t            p_meta_r, s_meta_r;
  logic                 p_v_r, s_v_r, o_v_r;
  logic                 o_go, s_go, p_go;

  // Stall chain from the output register back to the queue.
  assign o_go  = !o_v_r || !out_stall;
  assign s_go  = !s_v_r || o_go;
  assign p_go  = !p_v_r || s_go;
  assign q_pop = !q_empty && p_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_v_r <= 1'b0;
      s_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (p_go) begin
        p_v_r <= q_pop;
      end
      if (s_go) begin
        s_v_r <= p_v_r;
      end
      if (o_go) begin
        o_v_r <= s_v_r;
      end
    end
  end

  // Products of each tap with its coefficient.
  always_comb begin
    for (int ki = 0; ki < KERNEL_MAX; ki++) begin
      for (int kj = 0; kj < KERNEL_MAX; kj++) begin
        p_nxt[ki*KERNEL_MAX+kj] =
          $signed(q_taps[(ki*KERNEL_MAX+kj)*PIXEL_BITS +: PIXEL_BITS]) *
          $signed(coeffs[ki*CROW_BITS + kj*COEFF_BITS +: COEFF_BITS]);
      end
    end
  end

  // Row sums.
  always_comb begin
    for (int ki = 0; ki < KERNEL_MAX; ki++) begin
      rs_nxt[ki] = '0;
      for (int kj = 0; kj < KERNEL_MAX; kj++) begin
        rs_nxt[ki] = rs_nxt[ki] + RW'(p_r[ki*KERNEL_MAX+kj]);
      end
    end
  end

  // Final sum over the rows.
  always_comb begin
    fs = '0;
    for (int ki = 0; ki < KERNEL_MAX; ki++) begin
      fs = fs + SW'(rs_r[ki]);
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (p_go) begin
      p_r      <= p_nxt;
      p_meta_r <= q_meta;
    end
    if (s_go) begin
      rs_r     <= rs_nxt;
      s_meta_r <= p_meta_r;
    end
    if (o_go) begin
      out_conv_sum <= SUM_BITS'(fs);
      out_meta     <= s_meta_r;
    end
  end

  assign out_valid = o_v_r;

endmodule

### hdl/conv2d_valid_window.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// conv2d_valid_window
// Streaming valid-mode 2D window sum of products over a raster image.
// ---------------------------------------------------------------------------
// The block takes one pixel per clock cycle for as long as results are taken:
// a pixel is classified at its transfer and its window assembled in the cycle
// after; that window's result then passes the queue and the product, row-sum
// and output registers. One line store RAM, one word per column, is read when
// a pixel is taken and written back as that pixel leaves stage one, so it
// sustains one pixel per cycle; a four-entry queue decouples intake from the
// multiply and add stages, and intake stalls only when that queue is full.
// The line store needs no clearing pass: per-column valid bits give zero for
// columns not yet written. Configuration writes are always taken at once.
module conv2d_valid_window import cvw_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int KERNEL_MAX = DEF_KERNEL_MAX,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CIDX_BITS-1:0]  cfg_index,
  input  logic [CROW_BITS-1:0]  cfg_data,
  // Pixel channel.
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIXEL_BITS-1:0] in_pixel,
  // Result channel.
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SUM_BITS-1:0]   out_conv_sum,
  output logic [ROW_BITS-1:0]   out_row,
  output logic [COL_BITS-1:0]   out_col,
  output logic                  out_last_of_frame
);

  localparam int TW = KERNEL_MAX * KERNEL_MAX * PIXEL_BITS;
  localparam int MW = $bits(cvw_meta_t);

  cvw_cfg_t                        cfg_r;
  logic [COEFF_ROWS*CROW_BITS-1:0] coeff_r;
  logic                            q_push, q_pop, q_full, q_empty;
  logic [TW-1:0]                   f_taps;
  cvw_meta_t                       f_meta, b_meta, o_meta;
  logic [TW+MW-1:0]                q_head;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= WREG_BITS'(28);
      cfg_r.image_height <= HREG_BITS'(28);
      cfg_r.kernel_rows  <= KREG_BITS'(3);
      cfg_r.kernel_cols  <= KREG_BITS'(3);
      coeff_r            <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cvw_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_data[WREG_BITS-1:0];
        REG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_data[HREG_BITS-1:0];
        REG_KERNEL_ROWS:  cfg_r.kernel_rows  <= cfg_data[KREG_BITS-1:0];
        REG_KERNEL_COLS:  cfg_r.kernel_cols  <= cfg_data[KREG_BITS-1:0];
        REG_COEFF_ROW0:   coeff_r[0*CROW_BITS +: CROW_BITS] <= cfg_data;
        REG_COEFF_ROW1:   coeff_r[1*CROW_BITS +: CROW_BITS] <= cfg_data;
        REG_COEFF_ROW2:   coeff_r[2*CROW_BITS +: CROW_BITS] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Intake and window assembly.
  cvw_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .KERNEL_MAX (KERNEL_MAX),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_pixel (in_pixel),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_taps   (f_taps),
    .q_meta   (f_meta)
  );

  // Window queue.
  cvw_fifo #(
    .DW (TW + MW)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata ({f_taps, f_meta}),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .rdata (q_head)
  );

  assign b_meta = q_head[MW-1:0];

  // Multiply and add stages.
  cvw_mac #(
    .KERNEL_MAX (KERNEL_MAX),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_mac (
    .clk          (clk),
    .rst_n        (rst_n),
    .coeffs       (coeff_r),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .q_taps       (q_head[TW+MW-1:MW]),
    .q_meta       (b_meta),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_conv_sum (out_conv_sum),
    .out_meta     (o_meta)
  );

  assign out_row           = o_meta.row;
  assign out_col           = o_meta.col;
  assign out_last_of_frame = o_meta.last;

endmodule

### hdl/cvw_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cvw_checker
// Port-level checks on the window convolution block, bound to its top level.
// ---------------------------------------------------------------------------
module cvw_checker import cvw_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [SUM_BITS-1:0] out_conv_sum,
  input logic [ROW_BITS-1:0] out_row,
  input logic [COL_BITS-1:0] out_col,
  input logic                out_last_of_frame
);

  // A stalled result keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_conv_sum) &&
      $stable(out_row) && $stable(out_col) && $stable(out_last_of_frame))
    else $error("stalled result changed");

  // Reset empties the pipeline and opens intake.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // Intake only stalls once the result side has been held up.
  a_backp: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> $past(out_valid && out_stall))
    else $error("intake stalled without result back-pressure");

  // The result after a frame's last one starts the next frame at row zero.
  a_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_of_frame |=> !out_valid || out_row == '0)
    else $error("new frame did not start at row zero");

endmodule

bind conv2d_valid_window cvw_checker u_cvw_checker (.*);

### verif/tb_conv2d_valid_window.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_conv2d_valid_window
// Self-checking bench for the streaming window convolution block. A short
// table of directed transfers is followed by random images under many
// geometry and kernel settings. Every pixel transfer updates a behavioural
// window model, and each result is compared field by field in arrival order.
// ---------------------------------------------------------------------------
module tb_conv2d_valid_window;
  import cvw_pkg::*;

  localparam logic [CIDX_BITS-1:0] REG_SPARE = 3'd7;
  localparam int PIXEL_TARGET  = 1650;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 12;
  localparam int DIR_ROWS      = 37;

  typedef struct {
    logic [SUM_BITS-1:0] sum;
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col;
    logic                last;
  } conv_result_t;

  typedef struct {
    bit                          is_reg;
    logic [CIDX_BITS-1:0]        idx;
    logic [CROW_BITS-1:0]        data;
    bit                          typed;
    logic signed [SUM_BITS-1:0]  sum;
  } dir_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CIDX_BITS-1:0] cfg_index;
  logic [CROW_BITS-1:0] cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic [15:0]          in_pixel;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [SUM_BITS-1:0]  out_conv_sum;
  logic [ROW_BITS-1:0]  out_row;
  logic [COL_BITS-1:0]  out_col;
  logic                 out_last_of_frame;

  // Window model state and its copy of the settings.
  logic [WREG_BITS-1:0] geo_width;
  logic [HREG_BITS-1:0] geo_height;
  logic [KREG_BITS-1:0] geo_krows;
  logic [KREG_BITS-1:0] geo_kcols;
  logic [CROW_BITS-1:0] kernel_mem [3];
  logic [15:0]          line_mem [2][64];
  logic [15:0]          win_mem [3][2];
  int unsigned          col_cnt;
  int unsigned          row_cnt;

  conv_result_t pending_results[$];
  dir_row_t     dir_rows [DIR_ROWS];
  int           error_count = 0;
  int           idle_cycles = 0;
  int           stall_left = 0;
  int           stall_draw;
  bit           quiet = 1'b0;

  conv2d_valid_window u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_pixel          (in_pixel),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_conv_sum      (out_conv_sum),
    .out_row           (out_row),
    .out_col           (out_col),
    .out_last_of_frame (out_last_of_frame)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Advance the window model by one pixel; returns 1 when a result is due.
  function automatic bit window_step(input logic [15:0] px, output conv_result_t res);
    int unsigned w, h, kr, kc, c, ra, cb;
    logic [15:0] cur [3];
    logic [15:0] v;
    longint acc;
    bit hit, end_row, end_frame;
    w  = (geo_width == 0) ? 1 : ((geo_width > 64) ? 64 : geo_width);
    h  = (geo_height == 0) ? 1 : ((geo_height > HEIGHT_MAX) ? HEIGHT_MAX : geo_height);
    kr = (geo_krows == 0) ? 1 : geo_krows;
    kc = (geo_kcols == 0) ? 1 : geo_kcols;
    c  = col_cnt;
    end_row   = c >= w - 1;
    end_frame = end_row && row_cnt >= h - 1;
    cur[0] = px;
    cur[1] = line_mem[0][c];
    cur[2] = line_mem[1][c];
    hit = (row_cnt >= kr - 1) && (c >= kc - 1);
    res = '{default: '0};
    if (hit) begin
      acc = 0;
      for (int ki = 0; ki < kr; ki++) begin
        for (int kj = 0; kj < kc; kj++) begin
          ra = kr - 1 - ki;
          cb = kc - 1 - kj;
          v = (cb == 0) ? cur[ra] : win_mem[ra][cb-1];
          acc += longint'($signed(v)) * longint'($signed(kernel_mem[ki][16*kj +: 16]));
        end
      end
      res.sum  = acc[SUM_BITS-1:0];
      res.row  = ROW_BITS'(row_cnt - (kr - 1));
      res.col  = COL_BITS'(c - (kc - 1));
      res.last = end_frame;
    end
    // Shift the window columns and push the pixel down the line store.
    for (int a = 0; a < 3; a++) begin
      win_mem[a][1] = win_mem[a][0];
      win_mem[a][0] = cur[a];
    end
    line_mem[1][c] = line_mem[0][c];
    line_mem[0][c] = px;
    if (end_row) begin
      col_cnt = 0;
      row_cnt = end_frame ? 0 : row_cnt + 1;
    end else begin
      col_cnt = c + 1;
    end
    return hit;
  endfunction

  // Let every outstanding result arrive, then allow the pipeline to settle.
  task automatic drain_block();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_BITS-1:0] idx, input logic [CROW_BITS-1:0] data);
    drain_block();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:  geo_width  = data[WREG_BITS-1:0];
      REG_IMAGE_HEIGHT: geo_height = data[HREG_BITS-1:0];
      REG_KERNEL_ROWS:  geo_krows  = data[KREG_BITS-1:0];
      REG_KERNEL_COLS:  geo_kcols  = data[KREG_BITS-1:0];
      REG_COEFF_ROW0:   kernel_mem[0] = data;
      REG_COEFF_ROW1:   kernel_mem[1] = data;
      REG_COEFF_ROW2:   kernel_mem[2] = data;
      default: ;
    endcase
  endtask

  // One pixel transfer; a typed sum overrides the modelled one.
  task automatic send_pixel(input logic [15:0] px, input bit typed,
                            input logic [SUM_BITS-1:0] typed_sum);
    int gap;
    conv_result_t res;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (window_step(px, res)) begin
      if (typed) res.sum = typed_sum;
      pending_results.push_back(res);
    end
  endtask

  function automatic logic [15:0] draw_value();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Result sink: random stall after each transfer, and the comparison.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transfer with nothing expected: conv_sum %0d",
               $signed(out_conv_sum));
        error_count++;
      end else begin
        if (out_conv_sum !== pending_results[0].sum) begin
          $error("conv_sum expected %0d actual %0d",
                 $signed(pending_results[0].sum), $signed(out_conv_sum));
          error_count++;
        end
        if (out_row !== pending_results[0].row) begin
          $error("out_row expected %0d actual %0d", pending_results[0].row, out_row);
          error_count++;
        end
        if (out_col !== pending_results[0].col) begin
          $error("out_col expected %0d actual %0d", pending_results[0].col, out_col);
          error_count++;
        end
        if (out_last_of_frame !== pending_results[0].last) begin
          $error("last_of_frame expected %0d actual %0d",
                 pending_results[0].last, out_last_of_frame);
          error_count++;
        end
        void'(pending_results.pop_front());
      end
      stall_draw = quiet ? 0 : $urandom_range(0, 16);
      stall_left <= stall_draw;
      out_stall  <= (stall_draw != 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int sent;
    int count;
    dir_rows = '{
      // 2x2 image, single tap of 1.0: each sum is the pixel scaled by 256.
      '{1'b1, REG_IMAGE_WIDTH,  48'd2,      1'b0, '0},
      '{1'b1, REG_IMAGE_HEIGHT, 48'd2,      1'b0, '0},
      '{1'b1, REG_KERNEL_ROWS,  48'd1,      1'b0, '0},
      '{1'b1, REG_KERNEL_COLS,  48'd1,      1'b0, '0},
      '{1'b1, REG_COEFF_ROW0,   48'h0100,   1'b0, '0},
      '{1'b0, '0, 48'h7FFF, 1'b1,  35'sd8388352},
      '{1'b0, '0, 48'h8000, 1'b1, -35'sd8388608},
      '{1'b0, '0, 48'h0000, 1'b1,  35'sd0},
      '{1'b0, '0, 48'h0001, 1'b1,  35'sd256},
      // Most negative tap.
      '{1'b1, REG_COEFF_ROW0,   48'h8000,   1'b0, '0},
      '{1'b0, '0, 48'h8000, 1'b1,  35'sd1073741824},
      '{1'b0, '0, 48'h7FFF, 1'b1, -35'sd1073709056},
      '{1'b0, '0, 48'h0100, 1'b1, -35'sd8388608},
      '{1'b0, '0, 48'hFFFF, 1'b1,  35'sd32768},
      // 3x3 image under a full 3x3 kernel of most negative taps.
      '{1'b1, REG_IMAGE_WIDTH,  48'd3,      1'b0, '0},
      '{1'b1, REG_IMAGE_HEIGHT, 48'd3,      1'b0, '0},
      '{1'b1, REG_KERNEL_ROWS,  48'd3,      1'b0, '0},
      '{1'b1, REG_KERNEL_COLS,  48'd3,      1'b0, '0},
      '{1'b1, REG_COEFF_ROW0,   48'h800080008000, 1'b0, '0},
      '{1'b1, REG_COEFF_ROW1,   48'h800080008000, 1'b0, '0},
      '{1'b1, REG_COEFF_ROW2,   48'h800080008000, 1'b0, '0},
      '{1'b1, REG_SPARE,        48'hFFFFFFFFFFFF, 1'b0, '0},
      '{1'b0, '0, 48'h8000, 1'b0, '0},
      '{1'b0, '0, 48'h8000, 1'b0, '0},
      '{1'b0, '0, 48'h8000, 1'b0, '0},
      '{1'b0, '0, 48'h8000, 1'b0, '0},
      '{1'b0, '0, 48'h8000, 1'b0, '0},
      '{1'b0, '0, 48'h8000, 1'b0, '0},
      '{1'b0, '0, 48'h8000, 1'b0, '0},
      '{1'b0, '0, 48'h8000, 1'b0, '0},
      '{1'b0, '0, 48'h8000, 1'b1,  35'sd9663676416},
      // Image smaller than the kernel gives nothing.
      '{1'b1, REG_IMAGE_WIDTH,  48'd2,      1'b0, '0},
      '{1'b1, REG_IMAGE_HEIGHT, 48'd2,      1'b0, '0},
      '{1'b0, '0, 48'h1234, 1'b0, '0},
      '{1'b0, '0, 48'h8000, 1'b0, '0},
      '{1'b0, '0, 48'h7FFF, 1'b0, '0},
      '{1'b0, '0, 48'hFFFF, 1'b0, '0}
    };
    geo_width  = 7'd28;
    geo_height = 13'd28;
    geo_krows  = 2'd3;
    geo_kcols  = 2'd3;
    kernel_mem = '{default: '0};
    line_mem   = '{default: '0};
    win_mem    = '{default: '0};
    col_cnt    = 0;
    row_cnt    = 0;
    sent       = 0;
    rst_n     <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    in_valid  <= 1'b0;
    in_pixel  <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_reg) begin
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_pixel(dir_rows[i].data[15:0], dir_rows[i].typed, dir_rows[i].sum);
        sent++;
      end
    end

    // Random phases: new settings, then a run of pixels that may end mid-frame.
    while (sent < PIXEL_TARGET) begin
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 9))
          0: write_reg(REG_IMAGE_WIDTH, 48'd0);
          1: write_reg(REG_IMAGE_WIDTH, 48'd64);
          2: write_reg(REG_IMAGE_WIDTH, 48'd127);
          3: write_reg(REG_IMAGE_WIDTH, 48'($urandom_range(1, 64)));
          default: write_reg(REG_IMAGE_WIDTH, 48'($urandom_range(1, 8)));
        endcase
      end
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 9))
          0: write_reg(REG_IMAGE_HEIGHT, 48'd0);
          1: write_reg(REG_IMAGE_HEIGHT, 48'd4096);
          2: write_reg(REG_IMAGE_HEIGHT, 48'd8191);
          default: write_reg(REG_IMAGE_HEIGHT, 48'($urandom_range(1, 6)));
        endcase
      end
      if ($urandom_range(0, 1) == 0) write_reg(REG_KERNEL_ROWS, 48'($urandom_range(0, 3)));
      if ($urandom_range(0, 1) == 0) write_reg(REG_KERNEL_COLS, 48'($urandom_range(0, 3)));
      for (int r = 0; r < 3; r++) begin
        if ($urandom_range(0, 1) == 0) begin
          write_reg(REG_COEFF_ROW0 + CIDX_BITS'(r), {draw_value(), draw_value(), draw_value()});
        end
      end
      if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE, {$urandom, $urandom});
      count = $urandom_range(1, 60);
      repeat (count) begin
        send_pixel(draw_value(), 1'b0, '0);
        sent++;
      end
    end

    drain_block();
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
hdl/cvw_pkg.sv
hdl/cvw_ram.sv
hdl/cvw_front.sv
hdl/cvw_fifo.sv
hdl/cvw_mac.sv
hdl/conv2d_valid_window.sv
hdl/cvw_checker.sv
verif/tb_conv2d_valid_window.sv
